[design/igfb_pkg.sv]
// shared types and constants of the idle gap frame builder
`timescale 1ns / 1ps

package igfb_pkg;

  // frame end causes as carried on the result channel
  localparam logic [1:0] CAUSE_GAP   = 2'd0;
  localparam logic [1:0] CAUSE_FULL  = 2'd1;
  localparam logic [1:0] CAUSE_FLUSH = 2'd2;

  // input item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // configuration register indexes
  localparam logic [0:0] REG_GAP_TICKS = 1'b0;
  localparam logic [0:0] REG_MIN_EMIT  = 1'b1;

  localparam logic [15:0] GAP_TICKS_RESET = 16'd10;
  localparam logic [5:0]  MIN_EMIT_RESET  = 6'd3;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic load_out;
    logic finish;
  } igfb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_needed;
    logic last_byte;
    logic out_free;
  } igfb_stat_t;

endpackage

[design/igfb_if.sv]
// stream channel interfaces for input items and frame bytes
`timescale 1ns / 1ps

interface igfb_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface igfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [4:0] byte_position;
  logic [5:0] frame_length;
  logic [1:0] cause;
  logic       last_of_frame;

  modport source (output valid, output out_byte, output byte_position, output frame_length,
                  output cause, output last_of_frame, input ready);
  modport sink   (input valid, input out_byte, input byte_position, input frame_length,
                  input cause, input last_of_frame, output ready);
endinterface

[design/igfb_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module igfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/igfb_ctrl.sv]
// controller state machine: accept, per-byte read and load, frame finish
`timescale 1ns / 1ps

module igfb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  igfb_pkg::igfb_stat_t stat_i,
  output igfb_pkg::igfb_cmd_t  cmd_o
);

  import igfb_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_LOAD   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.emit_needed) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = stat_i.last_byte ? ST_FINISH : ST_READ;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a beat is only loaded into the output stage when it is free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> stat_i.out_free)
    else $error("output stage overwritten");

  // a read is always followed by its load phase
  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_LOAD)
    else $error("read not followed by load");

  // no new item while a frame is being sent
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !cmd_o.accept)
    else $error("item accepted during emit");

endmodule

[design/igfb_dp.sv]
// datapath: fill and idle counters, frame buffer, emit index and output stage
`timescale 1ns / 1ps

module igfb_dp #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 mode_i,
  input  logic [7:0]           data_byte_i,
  input  logic [15:0]          gap_ticks_i,
  input  logic [5:0]           min_emit_i,
  input  igfb_pkg::igfb_cmd_t  cmd_i,
  output igfb_pkg::igfb_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic [4:0]           byte_position_o,
  output logic [5:0]           frame_length_o,
  output logic [1:0]           cause_o,
  output logic                 last_of_frame_o
);

  import igfb_pkg::*;

  localparam int AW   = $clog2(BUFFER_BYTES);
  localparam int CW   = $clog2(BUFFER_BYTES + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] FULL_COUNT = CW'(BUFFER_BYTES);

  logic [CW-1:0] fill_q, fill_d;
  logic [15:0]   idle_q, idle_d;
  logic [CW-1:0] len_q, len_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [1:0]    cause_q, cause_d;
  logic          pend_byte_q, pend_byte_d;
  logic [7:0]    pend_data_q, pend_data_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    obyte_q;
  logic [4:0]    opos_q;
  logic [5:0]    olen_q;
  logic [1:0]    ocause_q;
  logic          olast_q;

  logic [15:0]   tick_idle;
  logic          gap_hit;
  logic          ge_min;
  logic          buf_full;
  logic          emit_needed;
  logic          last_byte;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // idle count raised with saturation at the gap, also pulled down if the gap was lowered
  assign tick_idle = (idle_q < gap_ticks_i) ? idle_q + 16'd1 : gap_ticks_i;

  always_comb begin
    if (mode_i == MODE_TICK) begin
      gap_hit = (fill_q != '0) && (tick_idle >= gap_ticks_i);
    end else begin
      gap_hit = (fill_q != '0) && (idle_q >= gap_ticks_i);
    end
  end

  assign ge_min    = CMPW'(fill_q) >= CMPW'(min_emit_i);
  assign buf_full  = (fill_q >= FULL_COUNT);
  assign last_byte = (CW'(idx_q) + CW'(1)) == len_q;

  always_comb begin
    if (mode_i == MODE_TICK) begin
      emit_needed = gap_hit && ge_min;
    end else begin
      emit_needed = gap_hit ? ge_min : buf_full;
    end
  end

  assign stat_o.emit_needed = emit_needed;
  assign stat_o.last_byte   = last_byte;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    fill_d      = fill_q;
    idle_d      = idle_q;
    len_d       = len_q;
    idx_d       = idx_q;
    cause_d     = cause_q;
    pend_byte_d = pend_byte_q;
    pend_data_d = pend_data_q;
    ram_we      = 1'b0;
    ram_waddr   = gap_hit ? '0 : fill_q[AW-1:0];
    ram_wdata   = data_byte_i;

    if (cmd_i.accept) begin
      idle_d      = (mode_i == MODE_TICK) ? tick_idle : 16'd0;
      len_d       = fill_q;
      idx_d       = '0;
      pend_byte_d = (mode_i == MODE_BYTE);
      pend_data_d = data_byte_i;
      if (mode_i == MODE_TICK) begin
        cause_d = CAUSE_FLUSH;
      end else begin
        cause_d = gap_hit ? CAUSE_GAP : CAUSE_FULL;
      end
      if (!emit_needed) begin
        if (mode_i == MODE_TICK) begin
          fill_d = gap_hit ? '0 : fill_q;
        end else begin
          // short frame on a gap is dropped, the byte opens the new one
          ram_we = 1'b1;
          fill_d = (gap_hit ? '0 : fill_q) + CW'(1);
        end
      end
    end

    if (cmd_i.load_out) begin
      idx_d = idx_q + AW'(1);
    end

    // frame sent: buffer restarts, with the held byte if the item was a byte
    if (cmd_i.finish) begin
      ram_waddr = '0;
      ram_wdata = pend_data_q;
      ram_we    = pend_byte_q;
      fill_d    = pend_byte_q ? CW'(1) : '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      idle_q      <= idle_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    idx_q       <= idx_d;
    cause_q     <= cause_d;
    pend_byte_q <= pend_byte_d;
    pend_data_q <= pend_data_d;
    if (cmd_i.load_out) begin
      obyte_q  <= ram_rdata;
      opos_q   <= 5'(idx_q);
      olen_q   <= 6'(len_q);
      ocause_q <= cause_q;
      olast_q  <= last_byte;
    end
  end

  igfb_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = obyte_q;
  assign byte_position_o = opos_q;
  assign frame_length_o  = olen_q;
  assign cause_o         = ocause_q;
  assign last_of_frame_o = olast_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_COUNT)
    else $error("fill count beyond buffer");

  a_idx_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out || cmd_i.rd_issue) |-> (CW'(idx_q) < len_q))
    else $error("emit index past frame length");

  // the buffer only restarts once the last byte of the frame has been loaded into the output stage
  a_finish_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> $past(cmd_i.load_out) && $past(last_byte))
    else $error("frame finished early");

endmodule

[design/idle_gap_frame_builder_unit.sv]
// top level of the idle gap frame builder: configuration registers, controller, datapath
//
//  channel  | dir | beat contents                                   | handshake
//  in_i     | in  | mode, data_byte                                 | valid/ready
//  out_o    | out | out_byte, byte_position, frame_length, cause,   | valid/ready
//           |     | last_of_frame                                   |
//  apb      | in  | gap_ticks at 0x0, min_emit_bytes at 0x4         | psel/penable, pready=1
//
//  an item that sends no frame is taken while the controller stays idle; one that sends an n byte
//  frame is followed by a read then a load of each byte from the frame ram, then a finish step
//  reset clears fill and idle counters and the output stage; buffer contents are not cleared
//  a stalled output holds the beat in flight and the emit waits until it is taken
//  a new item is taken while the last beat of the previous frame still waits
`timescale 1ns / 1ps

module idle_gap_frame_builder_unit #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  igfb_in_if.sink     in_i,
  igfb_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import igfb_pkg::*;

  logic [15:0] gap_ticks_q, gap_ticks_d;
  logic [5:0]  min_emit_q, min_emit_d;
  logic [0:0]  reg_idx;
  logic        cfg_we;

  igfb_cmd_t  cmd;
  igfb_stat_t stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    gap_ticks_d = gap_ticks_q;
    min_emit_d  = min_emit_q;
    unique case (reg_idx)
      REG_GAP_TICKS: begin
        prdata = {16'd0, gap_ticks_q};
        if (cfg_we) begin
          gap_ticks_d = pwdata[15:0];
        end
      end
      REG_MIN_EMIT: begin
        prdata = {26'd0, min_emit_q};
        if (cfg_we) begin
          min_emit_d = pwdata[5:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q <= GAP_TICKS_RESET;
      min_emit_q  <= MIN_EMIT_RESET;
    end else begin
      gap_ticks_q <= gap_ticks_d;
      min_emit_q  <= min_emit_d;
    end
  end

  igfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  igfb_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (in_i.mode),
    .data_byte_i     (in_i.data_byte),
    .gap_ticks_i     (gap_ticks_q),
    .min_emit_i      (min_emit_q),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_byte_o      (out_o.out_byte),
    .byte_position_o (out_o.byte_position),
    .frame_length_o  (out_o.frame_length),
    .cause_o         (out_o.cause),
    .last_of_frame_o (out_o.last_of_frame)
  );

endmodule

[verif/igfb_frame_checker.sv]
// frame checker: predicts emitted frame beats from accepted items and compares them
`timescale 1ns / 1ps

module igfb_frame_checker #(
  parameter int BUFFER_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  igfb_in_if          in_mon,
  igfb_out_if         out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fails_o,
  output int          pending_o
);
  import igfb_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [4:0] byte_position;
    logic [5:0] frame_length;
    logic [1:0] cause;
    logic       last_of_frame;
  } frame_beat_t;

  frame_beat_t beats_q[$];

  logic [7:0]  frame_mem [BUFFER_BYTES];
  logic [5:0]  fill_cnt;
  logic [15:0] idle_cnt;
  logic [15:0] gap_ticks_q;
  logic [5:0]  min_emit_q;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%t mismatch on %s: want %0h got %0h", $realtime, what, want, got);
    fails_o++;
  endtask

  function automatic void queue_frame(input logic [1:0] why);
    frame_beat_t beat;
    int          idx;
    for (idx = 0; idx < fill_cnt; idx++) begin
      beat.out_byte      = frame_mem[idx];
      beat.byte_position = idx[4:0];
      beat.frame_length  = fill_cnt;
      beat.cause         = why;
      beat.last_of_frame = (idx == fill_cnt - 1);
      beats_q            = {beats_q, beat};
    end
    fill_cnt = '0;
  endfunction

  // a frame that is too short is dropped, the buffer is cleared either way
  function automatic void close_on_gap(input logic [1:0] why);
    if (fill_cnt != 0 && idle_cnt >= gap_ticks_q) begin
      if (fill_cnt >= min_emit_q) queue_frame(why);
      fill_cnt = '0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_beat_t want;
    if (!rst_ni) begin
      beats_q.delete();
      fill_cnt    = '0;
      idle_cnt    = '0;
      gap_ticks_q = GAP_TICKS_RESET;
      min_emit_q  = MIN_EMIT_RESET;
      fails_o     = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (beats_q.size() == 0) begin
          report_mismatch("beat with nothing pending", 0, out_mon.out_byte);
        end else begin
          want = beats_q.pop_front();
          if (out_mon.out_byte !== want.out_byte)
            report_mismatch("out_byte", want.out_byte, out_mon.out_byte);
          if (out_mon.byte_position !== want.byte_position)
            report_mismatch("byte_position", want.byte_position, out_mon.byte_position);
          if (out_mon.frame_length !== want.frame_length)
            report_mismatch("frame_length", want.frame_length, out_mon.frame_length);
          if (out_mon.cause !== want.cause)
            report_mismatch("cause", want.cause, out_mon.cause);
          if (out_mon.last_of_frame !== want.last_of_frame)
            report_mismatch("last_of_frame", want.last_of_frame, out_mon.last_of_frame);
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_GAP_TICKS: gap_ticks_q = pwdata[15:0];
          REG_MIN_EMIT:  min_emit_q  = pwdata[5:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.mode == MODE_TICK) begin
          if (idle_cnt < gap_ticks_q) idle_cnt = idle_cnt + 16'd1;
          else idle_cnt = gap_ticks_q;
          close_on_gap(CAUSE_FLUSH);
        end else begin
          close_on_gap(CAUSE_GAP);
          if (fill_cnt >= BUFFER_BYTES) queue_frame(CAUSE_FULL);
          frame_mem[fill_cnt] = in_mon.data_byte;
          fill_cnt            = fill_cnt + 6'd1;
          idle_cnt            = '0;
        end
      end
    end
    pending_o = beats_q.size();
  end

endmodule

[verif/idle_gap_frame_builder_unit_tb.sv]
// testbench top: drives items and register writes, gives the verdict
`timescale 1ns / 1ps

module idle_gap_frame_builder_unit_tb;
  import igfb_pkg::*;

  localparam int BUFFER_BYTES = 32;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 46;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_beats;
  int cycle_count = 0;
  int items_sent = 0;
  bit calm_mode = 1'b0;

  igfb_in_if  in_ch ();
  igfb_out_if out_ch ();

  idle_gap_frame_builder_unit #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  igfb_frame_checker #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) frame_chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .fails_o  (fail_count),
    .pending_o(pending_beats)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_item(input logic mode, input logic [7:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.data_byte <= value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] value);
    send_item(MODE_BYTE, value);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  // hold the sender until every pending frame beat has come out
  task automatic drain_frames(input bit settle);
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_beats != 0) @(negedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input int gap, input int min_len, input bit calm, input int budget);
    int  first_item;
    int  len;
    int  ticks;
    bit  paused;
    calm_mode = calm;
    write_reg(REG_GAP_TICKS, 32'(gap));
    write_reg(REG_MIN_EMIT, 32'(min_len));
    first_item = items_sent;
    paused     = 1'b0;
    while (items_sent - first_item < budget) begin
      if ($urandom_range(0, 99) < 75) begin
        // burst of bytes then idle ticks, long bursts fill the buffer
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 10);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        if (gap > 20) ticks = $urandom_range(0, 3);
        else if ($urandom_range(0, 3) == 0) ticks = $urandom_range(0, gap);
        else ticks = gap + $urandom_range(0, 2);
        send_ticks(ticks);
      end else begin
        repeat ($urandom_range(1, 3))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
      if (!paused && $urandom_range(0, 5) == 0) begin
        drain_frames(1'b0);
        paused = 1'b1;
      end
    end
    drain_frames(1'b1);
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_BYTE;
    in_ch.data_byte = 8'h00;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: tick on an empty buffer, then a short frame left idle
    send_ticks(1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_ticks(3);
    drain_frames(1'b1);

    // gap lowered below the idle count: the next byte drops the short frame
    write_reg(REG_GAP_TICKS, 32'd2);
    send_byte(8'hA5);
    send_byte(8'h3C);
    send_byte(8'h5A);
    send_ticks(2);
    drain_frames(1'b1);

    // zero gap and zero minimum: every byte ends the frame before it
    write_reg(REG_GAP_TICKS, 32'd0);
    write_reg(REG_MIN_EMIT, 32'd0);
    send_byte(8'h01);
    send_byte(8'h80);
    send_ticks(1);
    drain_frames(1'b1);

    run_phase(3, 3, 1'b0, PHASE_ITEMS);
    run_phase(65535, 32, 1'b0, PHASE_ITEMS);
    run_phase(1, 1, 1'b1, PHASE_ITEMS);
    run_phase(0, 0, 1'b0, PHASE_ITEMS);
    run_phase(5, 40, 1'b0, PHASE_ITEMS);
    run_phase(2, 63, 1'b0, PHASE_ITEMS);
    run_phase(12, 16, 1'b0, PHASE_ITEMS);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
design/igfb_pkg.sv
design/igfb_if.sv
design/igfb_ram.sv
design/igfb_ctrl.sv
design/igfb_dp.sv
design/idle_gap_frame_builder_unit.sv
verif/igfb_frame_checker.sv
verif/idle_gap_frame_builder_unit_tb.sv
